// ===== hw/rtl/immgen_pkg.sv =====
// immediate generator package: format codes and instruction field constants
`default_nettype none

package immgen_pkg;

  // format selector codes
  typedef enum logic [3:0] {
    FMT_I   = 4'd0,
    FMT_S   = 4'd1,
    FMT_B   = 4'd2,
    FMT_U   = 4'd3,
    FMT_J   = 4'd4,
    FMT_CI  = 4'd5,
    FMT_CSS = 4'd6,
    FMT_CIW = 4'd7,
    FMT_CL  = 4'd8,
    FMT_CS  = 4'd9,
    FMT_CB  = 4'd10,
    FMT_CJ  = 4'd11
  } immgen_fmt_e;

  localparam int unsigned XLEN = 32;
  localparam int unsigned OP_W = 4;

  // 32-bit shift-right-arithmetic immediate fields
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [2:0] F3_SR      = 3'b101;
  localparam logic [6:0] F7_SRA     = 7'h20;

  // compressed quadrants
  localparam logic [1:0] CQ0 = 2'd0;
  localparam logic [1:0] CQ1 = 2'd1;
  localparam logic [1:0] CQ2 = 2'd2;

  // compressed funct3 codes, quadrant 0
  localparam logic [2:0] CF3_ADDI4SPN = 3'd0;
  localparam logic [2:0] CF3_LW       = 3'd2;
  localparam logic [2:0] CF3_SW       = 3'd6;
  // quadrant 1
  localparam logic [2:0] CF3_ADDI     = 3'd0;
  localparam logic [2:0] CF3_JAL      = 3'd1;
  localparam logic [2:0] CF3_LI       = 3'd2;
  localparam logic [2:0] CF3_LUI      = 3'd3;
  localparam logic [2:0] CF3_MISC_ALU = 3'd4;
  localparam logic [2:0] CF3_J        = 3'd5;
  localparam logic [2:0] CF3_BEQZ     = 3'd6;
  localparam logic [2:0] CF3_BNEZ     = 3'd7;
  // quadrant 2
  localparam logic [2:0] CF3_SLLI     = 3'd0;
  localparam logic [2:0] CF3_LWSP     = 3'd2;
  localparam logic [2:0] CF3_SWSP     = 3'd6;

  // misc-alu sub-op in bits 11:10
  localparam logic [1:0] CB_SRLI = 2'd0;
  localparam logic [1:0] CB_SRAI = 2'd1;
  localparam logic [1:0] CB_ANDI = 2'd2;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_SP   = 5'd2;

endpackage : immgen_pkg

`default_nettype wire

// ===== hw/rtl/immgen_decode.sv =====
// immediate generator decode: combinational reassembly of the immediate
`default_nettype none

module immgen_decode
  import immgen_pkg::*;
(
  input  wire logic [XLEN-1:0] instr_word_i,
  input  wire logic [OP_W-1:0] op_i,
  output logic      [XLEN-1:0] imm_o
);

  logic [XLEN-1:0] w;
  logic [15:0]     c;
  logic [1:0]      cq;
  logic [2:0]      cf3;
  logic [4:0]      crd;
  logic [XLEN-1:0] six_sext;
  logic [XLEN-1:0] six_zext;

  assign w        = instr_word_i;
  assign c        = instr_word_i[15:0];
  assign cq       = c[1:0];
  assign cf3      = c[15:13];
  assign crd      = c[11:7];
  assign six_sext = {{26{c[12]}}, c[12], c[6:2]};
  assign six_zext = {26'b0, c[12], c[6:2]};

  always_comb begin
    imm_o = '0;
    unique case (immgen_fmt_e'(op_i))
      FMT_I: begin
        imm_o = {{20{w[31]}}, w[31:20]};
        // srai carries funct7 in the immediate field, keep the shift amount only
        if (w[6:0] == OPC_OP_IMM && w[14:12] == F3_SR && w[31:25] == F7_SRA) begin
          imm_o[10] = 1'b0;
        end
      end
      FMT_S: imm_o = {{20{w[31]}}, w[31:25], w[11:7]};
      FMT_B: imm_o = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      FMT_U: imm_o = {w[31:12], 12'b0};
      FMT_J: imm_o = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      FMT_CI: begin
        if (cq == CQ1 && (cf3 == CF3_ADDI || cf3 == CF3_LI)) begin
          imm_o = six_sext;
        end else if (cq == CQ1 && cf3 == CF3_LUI) begin
          if (crd == REG_SP) begin
            // addi16sp
            imm_o = {{22{c[12]}}, c[12], c[4:3], c[5], c[2], c[6], 4'b0};
          end else begin
            imm_o = six_sext;
          end
        end else if (cq == CQ2 && cf3 == CF3_SLLI) begin
          imm_o = six_zext;
        end else if (cq == CQ2 && cf3 == CF3_LWSP && crd != REG_ZERO) begin
          imm_o = {24'b0, c[3:2], c[12], c[6:4], 2'b0};
        end
      end
      FMT_CSS: begin
        if (cq == CQ2 && cf3 == CF3_SWSP) begin
          imm_o = {24'b0, c[8:7], c[12:9], 2'b0};
        end
      end
      FMT_CIW: begin
        if (cq == CQ0 && cf3 == CF3_ADDI4SPN) begin
          imm_o = {22'b0, c[10:7], c[12:11], c[5], c[6], 2'b0};
        end
      end
      FMT_CL: begin
        if (cq == CQ0 && cf3 == CF3_LW) begin
          imm_o = {25'b0, c[5], c[12:10], c[6], 2'b0};
        end
      end
      FMT_CS: begin
        if (cq == CQ0 && cf3 == CF3_SW) begin
          imm_o = {25'b0, c[5], c[12:10], c[6], 2'b0};
        end
      end
      FMT_CB: begin
        if (cq == CQ1 && (cf3 == CF3_BEQZ || cf3 == CF3_BNEZ)) begin
          imm_o = {{23{c[12]}}, c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
        end else if (cq == CQ1 && cf3 == CF3_MISC_ALU) begin
          if (c[11:10] == CB_SRLI || c[11:10] == CB_SRAI) begin
            imm_o = six_zext;
          end else if (c[11:10] == CB_ANDI) begin
            imm_o = six_sext;
          end
        end
      end
      FMT_CJ: begin
        if (cq == CQ1 && (cf3 == CF3_JAL || cf3 == CF3_J)) begin
          imm_o = {{20{c[12]}}, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11],
                   c[5:3], 1'b0};
        end
      end
      default: imm_o = '0;
    endcase
  end

endmodule : immgen_decode

`default_nettype wire

// ===== hw/rtl/riscv_immediate_generator.sv =====
// riscv immediate generator top level: input register, decode, result register
// an accepted word is held in the input register, decoded, then registered in the result register before it is offered
// throughput: one word per cycle while the output is not stalled, set by the two-register pipeline with no loop
// while a result waits in the output register the input register takes one more word,
// then the input stalls until the result leaves
// reset: rst_ni clears only the valid bits of both registers, payload is not reset
`default_nettype none

module riscv_immediate_generator
  import immgen_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input channel
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [XLEN-1:0]        instr_word_i,
  input  wire logic [OP_W-1:0]        op_i,
  // output channel
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [XLEN-1:0]      imm_value_o
);

  // input register stage
  logic            in_valid_q;
  logic [XLEN-1:0] instr_q;
  logic [OP_W-1:0] op_q;

  // result register stage
  logic            out_valid_q;
  logic [XLEN-1:0] imm_q;
  logic [XLEN-1:0] imm_d;

  logic out_load;  // result register takes a new word (or drains)
  logic in_load;   // input register takes a new word (or drains)

  // result register is free when empty or when its word leaves this cycle
  assign out_load   = !out_valid_q || !out_stall_i;
  // input register is free when empty or when its word moves to the result stage
  assign in_load    = !in_valid_q || out_load;
  assign in_stall_o = !in_load;

  // immediate reassembly between the two registers
  immgen_decode u_decode (
    .instr_word_i (instr_q),
    .op_i         (op_q),
    .imm_o        (imm_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      instr_q <= instr_word_i;
      op_q    <= op_i;
    end
    if (out_load && in_valid_q) begin
      imm_q <= imm_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign imm_value_o = $signed(imm_q);

  // a full pipeline under output back-pressure must push back on the input
  a_full_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input not stalled with both stages full and output stalled");

  // an accepted word lands in the input register
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_valid_q)
    else $error("accepted word lost before input register");

  // selector codes with no format give zero
  a_bad_op_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && in_valid_q && op_q[3] && op_q[2] |=> imm_q == '0)
    else $error("unused format code produced nonzero immediate");

  // upper immediates have the low twelve bits clear
  a_u_low_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && in_valid_q && op_q == FMT_U |=> imm_q[11:0] == '0)
    else $error("u-format immediate has low bits set");

endmodule : riscv_immediate_generator

`default_nettype wire
